// ----- hdl/sidba_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sidba_pkg: shared types and constants for the sequence id allocator
// Bitmap geometry, op and status codes, beat structs and the sequencer states.
// ----------------------------------------------------------------------------
package sidba_pkg;

  localparam int NUM_IDS   = 64;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CAND_W    = WORD_AW + BIT_W;
  localparam int ID_W      = 8;
  localparam int ID_OUT_W  = 6;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TEST    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NONE_FREE   = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_NOT_ALLOC   = 3'd3,
    ST_RESERVED    = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_t;

  typedef struct packed {
    op_t            op;
    logic [ID_W-1:0] id_in;
  } req_t;

  typedef struct packed {
    logic [ID_OUT_W-1:0] id_out;
    status_t             status;
    logic                is_free;
  } rsp_t;

  // Position of the lowest clear bit; 31 for a full word.
  function automatic logic [BIT_W-1:0] lowest_clear(input word_t w);
    logic [BIT_W-1:0] b;
    b = BIT_W'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        b = BIT_W'(i);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sequence_id_bitmap_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_id_bitmap_allocator_unit: bitmap based sequence id allocator
// Allocates, releases and tests ids held as used bits in a word RAM.
// ----------------------------------------------------------------------------
// Release, test: word read on acceptance in S_IDLE, result registered on leaving S_EVAL.
// Allocate: result registered after the number of words visited (1 to NUM_WORDS),
//   one RAM read per word.
// Requests are handled one at a time; a new request is taken the cycle after the
//   previous result is registered, even if unclaimed.
// Reset (rst, synchronous): all ids free via per-word valid bits, word pointer
//   and reserved id cleared; no clearing pass over the RAM.
module sequence_id_bitmap_allocator_unit
  import sidba_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [ID_W-1:0] cfg_wdata,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire req_t            req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output rsp_t                 rsp
);

  state_t             state, state_next;
  req_t               cur;
  logic [WORD_AW-1:0] addr;
  logic [WORD_AW-1:0] scan_cnt;
  logic [WORD_AW-1:0] word_ptr;
  logic [ID_W-1:0]    reserved_id;
  logic [NUM_WORDS-1:0] valid;
  logic               rd_valid;

  logic               ram_re, ram_we;
  logic [WORD_AW-1:0] ram_raddr;
  word_t              ram_rdata, ram_wdata;

  word_t              word;
  logic [BIT_W-1:0]   lc;
  logic [CAND_W-1:0]  cand;
  logic               alloc_hit;
  logic               last_word;
  logic [WORD_AW-1:0] next_addr;
  logic [WORD_AW-1:0] req_addr;
  logic [BIT_W-1:0]   bit_idx;
  logic               in_range;
  logic               wr_req, advance, finish;
  rsp_t               res;

  assign req_ready = (state == S_IDLE);

  // Invalid entries read as all free
  assign word      = rd_valid ? ram_rdata : '0;
  assign lc        = lowest_clear(word);
  assign cand      = {addr, lc};
  assign alloc_hit = (word != '1) && (32'(cand) != 32'(reserved_id))
                     && (32'(cand) < 32'(NUM_IDS));
  assign last_word = (scan_cnt == WORD_AW'(NUM_WORDS - 1));
  assign next_addr = (addr == WORD_AW'(NUM_WORDS - 1)) ? '0 : addr + 1'b1;
  assign req_addr  = WORD_AW'(req.id_in >> BIT_W);
  assign bit_idx   = cur.id_in[BIT_W-1:0];
  assign in_range  = 32'(cur.id_in) < 32'(NUM_IDS);

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = addr;
    ram_wdata  = word;
    wr_req     = 1'b0;
    advance    = 1'b0;
    finish     = 1'b0;
    ram_we     = 1'b0;
    res        = '0;
    res.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ram_re     = 1'b1;
          ram_raddr  = (req.op == OP_ALLOC) ? word_ptr : req_addr;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (cur.op)
          OP_ALLOC: begin
            if (alloc_hit) begin
              res.id_out = ID_OUT_W'(cand);
              ram_wdata  = word | (word_t'(1) << lc);
              wr_req     = 1'b1;
            end else begin
              res.status = ST_NONE_FREE;
              advance    = !last_word;
            end
          end
          OP_RELEASE: begin
            if (cur.id_in == reserved_id) begin
              res.status = ST_RESERVED;
            end else if (!in_range) begin
              res.status = ST_OUT_OF_RANGE;
            end else if (!word[bit_idx]) begin
              res.status = ST_NOT_ALLOC;
            end else begin
              ram_wdata = word & ~(word_t'(1) << bit_idx);
              wr_req    = 1'b1;
            end
          end
          OP_TEST: begin
            if (!in_range) begin
              res.status = ST_OUT_OF_RANGE;
            end else begin
              res.is_free = !word[bit_idx];
            end
          end
          default: ;
        endcase
        if (advance) begin
          ram_re    = 1'b1;
          ram_raddr = next_addr;
        end else if (!rsp_valid || rsp_ready) begin
          finish     = 1'b1;
          ram_we     = wr_req;
          state_next = S_IDLE;
        end else begin
          // hold: re-read the same word while the result beat is blocked
          ram_re = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      word_ptr    <= '0;
      reserved_id <= '0;
      valid       <= '0;
      rd_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        reserved_id <= cfg_wdata;
      end
      if (ram_re) begin
        rd_valid <= valid[ram_raddr];
      end
      if (ram_we) begin
        valid[addr] <= 1'b1;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
        if (cur.op == OP_ALLOC && alloc_hit) begin
          word_ptr <= addr;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur      <= req;
      addr     <= ram_raddr;
      scan_cnt <= '0;
    end else if (advance) begin
      addr     <= next_addr;
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (finish) begin
      rsp <= res;
    end
  end

  sidba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .AW    (WORD_AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_read_on_accept_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !req_valid) |-> !ram_re)
    else $error("bitmap read issued without a request beat");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(addr)])
    else $error("written bitmap word not marked valid");

  a_grant_not_reserved: assert property (@(posedge clk) disable iff (rst)
    (ram_we && cur.op == OP_ALLOC) |-> (32'(cand) != 32'(reserved_id)))
    else $error("reserved id granted");

  a_rsp_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_EVAL))
    else $error("result beat raised outside evaluation");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (32'(scan_cnt) < 32'(NUM_WORDS)))
    else $error("allocate scan ran past the last word");

endmodule
`default_nettype wire

// ----- hdl/sidba_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sidba_ram: simple dual-port RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module sidba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
